FILE: hdl/rbr_pkg.sv
// ----------------------------------------------------------------------------
// rbr_pkg
// Types and constants shared by the rounded button rasterizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbr_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_RECT_LEFT     = 3'd0;
	localparam logic [2:0] REG_RECT_TOP      = 3'd1;
	localparam logic [2:0] REG_RECT_WIDTH    = 3'd2;
	localparam logic [2:0] REG_RECT_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_CORNER_RADIUS = 3'd4;
	localparam logic [2:0] REG_BUTTON_LOOK   = 3'd5;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;

	// button looks (code 3 behaves as normal)
	localparam logic [1:0] LOOK_NORMAL  = 2'd0;
	localparam logic [1:0] LOOK_HOVER   = 2'd1;
	localparam logic [1:0] LOOK_PRESSED = 2'd2;

	// colors
	localparam logic [23:0] FILL_NORMAL  = 24'h2B5BB5;
	localparam logic [23:0] FILL_HOVER   = 24'h1E4A9A;
	localparam logic [23:0] FILL_PRESSED = 24'h174080;
	localparam logic [23:0] EDGE_LIGHT   = 24'h66BBFF;
	localparam logic [23:0] EDGE_DARK    = 24'h0077CC;

	// reset values
	localparam logic [5:0]  RADIUS_RESET       = 6'd6;
	localparam logic [12:0] SCREEN_WIDTH_RESET = 13'd1024;

	localparam int DELTA_BITS = 6;
	localparam int COLOR_BITS = 24;

	typedef enum logic [1:0] {
		EDGE_NONE = 2'd0,
		EDGE_IS_LIGHT = 2'd1,
		EDGE_IS_DARK = 2'd2
	} edge_kind_t;

	typedef struct packed {
		logic signed [12:0] rect_left;
		logic signed [12:0] rect_top;
		logic [11:0]        rect_width;
		logic [11:0]        rect_height;
		logic [5:0]         corner_radius;
		logic [1:0]         button_look;
		logic [12:0]        screen_width;
	} cfg_t;

	// classified pixel handed from the front to the back
	typedef struct packed {
		logic                  clip_ok;
		edge_kind_t            edge_kind;
		logic                  in_rect;
		logic                  left;
		logic                  right;
		logic                  top;
		logic                  bottom;
		logic [DELTA_BITS-1:0] dx_left;
		logic [DELTA_BITS-1:0] dx_right;
		logic [DELTA_BITS-1:0] dy_top;
		logic [DELTA_BITS-1:0] dy_bottom;
	} class_t;

	typedef struct packed {
		logic                  write_enable;
		logic [COLOR_BITS-1:0] pixel_color;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/rounded_button_rasterizer.sv
// ----------------------------------------------------------------------------
// rounded_button_rasterizer
// Per-pixel coverage and color of a beveled button with rounded corners.
// ----------------------------------------------------------------------------
// One pixel coordinate is taken per clock while full is low, and one result
// comes back for each, in order: write_enable and the RGB888 color (zero
// when not written). A pixel pushed at one edge is classified and stored in
// a four-entry queue at that edge, is resolved by the corner tests and lands
// in a two-entry result queue once that queue has room; a steady stream runs
// at one pixel per clock while the consumer keeps popping. full rises only
// when the consumer stops popping long enough to fill both queues.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high) and must only change while no pixel is in
// flight.
`default_nettype none

module rounded_button_rasterizer #(
	parameter int SCREEN_HEIGHT = 768,
	parameter int COORD_BITS    = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel input
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	// result output
	output logic                       empty,
	input  wire logic                  pop,
	output logic                       write_enable,
	output logic [23:0]                pixel_color,
	// configuration
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [12:0]           cfg_data
);

	import rbr_pkg::*;

	localparam int MID_DEPTH = 4;
	localparam int RES_DEPTH = 2;

	cfg_t    cfg_q;
	class_t  cls_wr, cls_rd;
	logic    mid_full, mid_empty, mid_pop;
	logic    res_push, res_full;
	result_t res_wr, res_rd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_left     <= '0;
			cfg_q.rect_top      <= '0;
			cfg_q.rect_width    <= '0;
			cfg_q.rect_height   <= '0;
			cfg_q.corner_radius <= RADIUS_RESET;
			cfg_q.button_look   <= LOOK_NORMAL;
			cfg_q.screen_width  <= SCREEN_WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RECT_LEFT:     cfg_q.rect_left     <= $signed(cfg_data);
				REG_RECT_TOP:      cfg_q.rect_top      <= $signed(cfg_data);
				REG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_data[11:0];
				REG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_data[11:0];
				REG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_data[5:0];
				REG_BUTTON_LOOK:   cfg_q.button_look   <= cfg_data[1:0];
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify incoming pixel
	rbr_front #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.cfg    (cfg_q),
		.cls    (cls_wr)
	);

	assign full = mid_full;

	// queue between front and back
	rbr_queue #(
		.WIDTH($bits(class_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(cls_wr),
		.full   (mid_full),
		.pop    (mid_pop),
		.rd_data(cls_rd),
		.empty  (mid_empty)
	);

	// back: corner tests and color
	rbr_back u_back (
		.cfg      (cfg_q),
		.cls      (cls_rd),
		.cls_valid(~mid_empty),
		.cls_pop  (mid_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_wr)
	);

	// result queue
	rbr_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res_wr),
		.full   (res_full),
		.pop    (pop),
		.rd_data(res_rd),
		.empty  (empty)
	);

	assign write_enable = res_rd.write_enable;
	assign pixel_color  = res_rd.pixel_color;

endmodule

`default_nettype wire

FILE: hdl/rbr_queue.sv
// ----------------------------------------------------------------------------
// rbr_queue
// Small first-in first-out queue with registered storage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_queue #(
	parameter int WIDTH,
	parameter int DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointer wrap at the last entry
	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		logic [PTR_BITS-1:0] n;
		if (p == PTR_BITS'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rbr_front.sv
// ----------------------------------------------------------------------------
// rbr_front
// Classifies a pixel against the button: clipping, bevel edges, rectangle
// and the corner region with its offsets from the circle centers.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_front #(
	parameter int SCREEN_HEIGHT,
	parameter int COORD_BITS
) (
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	input  wire rbr_pkg::cfg_t         cfg,
	output rbr_pkg::class_t            cls
);

	import rbr_pkg::*;

	// signed working width covering coordinates and the button extents
	localparam int CW = ((COORD_BITS > 13) ? COORD_BITS : 13) + 3;

	logic signed [CW-1:0] px, py, x, y, w, h, r;
	logic signed [CW-1:0] xw, yh, xl, xr, yt, yb;
	logic signed [CW-1:0] dxl, dxr, dyt, dyb;
	logic                 rows_ok, cols_ok;
	logic                 dark_r, light_l, dark_b, light_t;
	edge_kind_t           edge_sel;

	// operands
	always_comb begin
		px = $signed({{(CW-COORD_BITS){1'b0}}, pixel_x});
		py = $signed({{(CW-COORD_BITS){1'b0}}, pixel_y});
		x  = CW'(cfg.rect_left);
		y  = CW'(cfg.rect_top);
		if (cfg.button_look == LOOK_PRESSED) begin
			y = y + CW'(2);
		end
		w  = $signed({{(CW-12){1'b0}}, cfg.rect_width});
		h  = $signed({{(CW-12){1'b0}}, cfg.rect_height});
		r  = $signed({{(CW-6){1'b0}}, cfg.corner_radius});
		xw = x + w;
		yh = y + h;
		xl = x + r;
		xr = xw - r;
		yt = y + r;
		yb = yh - r;
	end

	// bevel edges, priority right, left, bottom, top
	always_comb begin
		rows_ok = (px >= xl) && (px < xr);
		cols_ok = (py >= yt) && (py < yb);
		dark_r  = cols_ok && ((px == xw - CW'(1)) || (px == xw - CW'(2)));
		light_l = cols_ok && ((px == x) || (px == x + CW'(1)));
		dark_b  = rows_ok && ((py == yh - CW'(1)) || (py == yh - CW'(2)));
		light_t = rows_ok && ((py == y) || (py == y + CW'(1)));
		if (dark_r) begin
			edge_sel = EDGE_IS_DARK;
		end else if (light_l) begin
			edge_sel = EDGE_IS_LIGHT;
		end else if (dark_b) begin
			edge_sel = EDGE_IS_DARK;
		end else if (light_t) begin
			edge_sel = EDGE_IS_LIGHT;
		end else begin
			edge_sel = EDGE_NONE;
		end
	end

	// clipping, rectangle and corner region
	always_comb begin
		cls.edge_kind = edge_sel;
		cls.clip_ok = (px < $signed({{(CW-13){1'b0}}, cfg.screen_width}))
			&& (py < CW'(SCREEN_HEIGHT));
		cls.in_rect = (px >= x) && (px < xw) && (py >= y) && (py < yh);
		cls.left    = px < xl;
		cls.right   = px >= xr;
		cls.top     = py < yt;
		cls.bottom  = py >= yb;
		// offsets lie in 1..radius whenever the corner test is used
		dxl = xl - px;
		dxr = px - xr + CW'(1);
		dyt = yt - py;
		dyb = py - yb + CW'(1);
		cls.dx_left   = dxl[DELTA_BITS-1:0];
		cls.dx_right  = dxr[DELTA_BITS-1:0];
		cls.dy_top    = dyt[DELTA_BITS-1:0];
		cls.dy_bottom = dyb[DELTA_BITS-1:0];
	end

endmodule

`default_nettype wire

FILE: hdl/rbr_back.sv
// ----------------------------------------------------------------------------
// rbr_back
// Runs the quarter-circle corner tests on a classified pixel and picks
// the final write enable and color.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_back (
	input  wire rbr_pkg::cfg_t   cfg,
	input  wire rbr_pkg::class_t cls,
	input  wire logic            cls_valid,
	output logic                 cls_pop,
	input  wire logic            res_full,
	output logic                 res_push,
	output rbr_pkg::result_t     res
);

	import rbr_pkg::*;

	localparam int SQ_BITS  = 2 * DELTA_BITS;
	localparam int SUM_BITS = SQ_BITS + 1;

	logic [SQ_BITS-1:0]  sq_l, sq_r, sq_t, sq_b, sq_rad;
	logic                out_lt, out_rt, out_lb, out_rb;
	logic                corner_out;
	logic                body;
	logic [COLOR_BITS-1:0] fill;

	// transaction moves when a classified pixel waits and the result queue has room
	assign cls_pop  = cls_valid & ~res_full;
	assign res_push = cls_pop;

	// squared offsets and radius
	always_comb begin
		sq_l   = SQ_BITS'(cls.dx_left) * SQ_BITS'(cls.dx_left);
		sq_r   = SQ_BITS'(cls.dx_right) * SQ_BITS'(cls.dx_right);
		sq_t   = SQ_BITS'(cls.dy_top) * SQ_BITS'(cls.dy_top);
		sq_b   = SQ_BITS'(cls.dy_bottom) * SQ_BITS'(cls.dy_bottom);
		sq_rad = SQ_BITS'(cfg.corner_radius) * SQ_BITS'(cfg.corner_radius);
	end

	// corner tests
	always_comb begin
		out_lt = (SUM_BITS'(sq_l) + SUM_BITS'(sq_t)) > SUM_BITS'(sq_rad);
		out_rt = (SUM_BITS'(sq_r) + SUM_BITS'(sq_t)) > SUM_BITS'(sq_rad);
		out_lb = (SUM_BITS'(sq_l) + SUM_BITS'(sq_b)) > SUM_BITS'(sq_rad);
		out_rb = (SUM_BITS'(sq_r) + SUM_BITS'(sq_b)) > SUM_BITS'(sq_rad);
		corner_out = (cls.left & cls.top & out_lt) | (cls.right & cls.top & out_rt)
			| (cls.left & cls.bottom & out_lb) | (cls.right & cls.bottom & out_rb);
		body = cls.in_rect & ~corner_out;
	end

	// fill color per look
	always_comb begin
		case (cfg.button_look)
			LOOK_HOVER:   fill = FILL_HOVER;
			LOOK_PRESSED: fill = FILL_PRESSED;
			default:      fill = FILL_NORMAL;
		endcase
	end

	// final selection
	always_comb begin
		res.write_enable = 1'b0;
		res.pixel_color  = '0;
		if (cls.clip_ok) begin
			case (cls.edge_kind)
				EDGE_IS_DARK: begin
					res.write_enable = 1'b1;
					res.pixel_color  = EDGE_DARK;
				end
				EDGE_IS_LIGHT: begin
					res.write_enable = 1'b1;
					res.pixel_color  = EDGE_LIGHT;
				end
				default: begin
					if (body) begin
						res.write_enable = 1'b1;
						res.pixel_color  = fill;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire
